// ===== hw/rtl/huffman_code_bit_packer_assert.svh =====
// Assertion macros shared by the Huffman bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HCBP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication, checked outside reset.
`define HCBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

// ===== hw/rtl/hcbp_pkg.sv =====
// Shared constants and types of the Huffman code bit packer.
package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int PAD_W  = 3;

    localparam int SYM_AW    = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W   = CODE_W + LEN_W;
    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // Bit accumulator: up to seven held bits plus one full code.
    // The count must also hold two bytes for the emit compare.
    localparam int ACC_W = LEN_LIMIT + BYTE_W;
    localparam int CNT_W = $clog2(ACC_W + 1);
    localparam int SH_W  = CNT_W + 1;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    // Transaction after the table lookup stage.
    typedef struct packed {
        logic [1:0]        mode;
        logic              err;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } item_t;

endpackage

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// Huffman encoder back end: code table lookup feeding an MSB-first bit packer.
// Flush or rejected load: lookup stage register, then output register. Encode: lookup
// stage, then bit accumulator, then output register for its first byte; more bytes follow
// per cycle while out_stall is low. Throughput: one transaction per cycle unless stalled;
// an encode yields at most four bytes; a later flush or rejected load waits for them.
// Reset (rst_n, async): entry valid bits clear so every length reads zero; packer empty.
module huffman_code_bit_packer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [hcbp_pkg::SYM_W-1:0]   symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]  code_word,
    input  logic [hcbp_pkg::LEN_W-1:0]   code_length,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]  out_byte,
    output logic [hcbp_pkg::PAD_W-1:0]   pad_bits,
    output logic                         last,
    output logic                         load_error
);

    logic            item_valid;
    hcbp_pkg::item_t item;
    logic            take;

    // Table lookup stage
    hcbp_lookup u_lookup (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take)
    );

    // Bit packing and output
    hcbp_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .pad_bits   (pad_bits),
        .last       (last),
        .load_error (load_error)
    );

endmodule

// ===== hw/rtl/hcbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/hcbp_lookup.sv =====
// Code table (RAM plus per-entry valid bits) and the lookup stage register.
module hcbp_lookup (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 mode,
    input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] code_word,
    input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
    output logic                       item_valid,
    output hcbp_pkg::item_t            item,
    input  logic                       take
);

    logic                           accept;
    logic                           sym_ok;
    logic                           len_bad;
    logic                           wr_en;
    logic                           rd_en;
    logic [hcbp_pkg::SYM_AW-1:0]    addr;
    logic [hcbp_pkg::CODE_W:0]      mask_wide;
    logic [hcbp_pkg::ENTRY_W-1:0]   wr_data;
    logic [hcbp_pkg::ENTRY_W-1:0]   rd_data;
    logic [hcbp_pkg::SYMBOL_COUNT-1:0] vld_reg;

    logic       s1_valid_reg;
    logic [1:0] s1_mode_reg;
    logic       s1_err_reg;
    logic       s1_hit_reg;

    // Input decode
    assign accept  = in_valid & ~in_stall;
    assign in_stall = s1_valid_reg & ~take;
    assign sym_ok  = ({1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT));
    assign len_bad = code_length > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT);
    assign addr    = symbol[hcbp_pkg::SYM_AW-1:0];

    // Table write on load, bits above the code length cleared
    assign mask_wide = ~({(hcbp_pkg::CODE_W + 1){1'b1}} << code_length);
    assign wr_data   = {code_length, code_word & mask_wide[hcbp_pkg::CODE_W-1:0]};
    assign wr_en     = accept & (mode == hcbp_pkg::MODE_LOAD) & ~len_bad & sym_ok;
    assign rd_en     = accept & (mode == hcbp_pkg::MODE_ENCODE);

    hcbp_ram #(
        .WIDTH (hcbp_pkg::ENTRY_W),
        .DEPTH (hcbp_pkg::SYMBOL_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // Entry valid bits: an unwritten entry reads as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[addr] <= 1'b1;
        end
    end

    // Lookup stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Lookup stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= mode;
            s1_err_reg  <= len_bad;
            s1_hit_reg  <= vld_reg[addr] & sym_ok;
        end
    end

    assign item_valid = s1_valid_reg;
    assign item.mode  = s1_mode_reg;
    assign item.err   = s1_err_reg;
    assign item.code  = s1_hit_reg ? rd_data[hcbp_pkg::CODE_W-1:0] : '0;
    assign item.len   = s1_hit_reg ? rd_data[hcbp_pkg::ENTRY_W-1 -: hcbp_pkg::LEN_W] : '0;

endmodule

// ===== hw/rtl/hcbp_packer.sv =====
// Bit accumulator that packs code bits MSB first and the output register.
`include "huffman_code_bit_packer_assert.svh"

module hcbp_packer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  hcbp_pkg::item_t             item,
    output logic                        take,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [hcbp_pkg::BYTE_W-1:0] out_byte,
    output logic [hcbp_pkg::PAD_W-1:0]  pad_bits,
    output logic                        last,
    output logic                        load_error
);

    logic [hcbp_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [hcbp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [hcbp_pkg::ACC_W-1:0]  acc_base;
    logic [hcbp_pkg::CNT_W-1:0]  cnt_base;
    logic [hcbp_pkg::SH_W-1:0]   shamt;
    logic [hcbp_pkg::ACC_W-1:0]  code_ext;

    logic                        out_valid_reg;
    logic [hcbp_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [hcbp_pkg::PAD_W-1:0]  pad_reg, pad_next;
    logic                        last_reg, last_next;
    logic                        err_reg, err_next;
    logic                        out_load;

    logic out_free;
    logic emit;
    logic room;
    logic need_out;
    logic is_flush;

    // Byte emission and admission of the next transaction
    assign out_free = ~out_valid_reg | ~out_stall;
    assign emit     = (cnt_reg >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W)) & out_free;
    assign cnt_base = emit ? cnt_reg - hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W) : cnt_reg;
    assign acc_base = emit ? (acc_reg << hcbp_pkg::BYTE_W) : acc_reg;
    assign room     = (cnt_reg < hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W))
                    | (emit & (cnt_reg < hcbp_pkg::CNT_W'(2 * hcbp_pkg::BYTE_W)));
    assign is_flush = (item.mode == hcbp_pkg::MODE_FLUSH);
    assign need_out = is_flush | ((item.mode == hcbp_pkg::MODE_LOAD) & item.err);
    assign take     = item_valid & room
                    & (~need_out | ((cnt_reg < hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W)) & out_free));

    // Place the code just below the held bits
    assign code_ext = hcbp_pkg::ACC_W'(item.code);
    assign shamt    = hcbp_pkg::SH_W'(hcbp_pkg::ACC_W) - {1'b0, cnt_base}
                    - hcbp_pkg::SH_W'(item.len);

    // Accumulator and output-register next state
    always_comb
    begin
        acc_next      = acc_base;
        cnt_next      = cnt_base;
        out_load      = emit;
        out_byte_next = acc_reg[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];
        pad_next      = '0;
        last_next     = (cnt_reg < hcbp_pkg::CNT_W'(2 * hcbp_pkg::BYTE_W));
        err_next      = 1'b0;
        if (take)
        begin
            case (hcbp_pkg::mode_t'(item.mode))
                hcbp_pkg::MODE_ENCODE:
                begin
                    acc_next = acc_base | (code_ext << shamt);
                    cnt_next = cnt_base + hcbp_pkg::CNT_W'(item.len);
                end
                hcbp_pkg::MODE_FLUSH:
                begin
                    if (cnt_reg != '0)
                    begin
                        out_load      = 1'b1;
                        out_byte_next = acc_reg[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];
                        pad_next      = hcbp_pkg::PAD_W'(hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W)
                                        - cnt_reg);
                        last_next     = 1'b1;
                    end
                    acc_next = '0;
                    cnt_next = '0;
                end
                hcbp_pkg::MODE_LOAD:
                begin
                    if (item.err)
                    begin
                        out_load      = 1'b1;
                        out_byte_next = '0;
                        pad_next      = '0;
                        last_next     = 1'b1;
                        err_next      = 1'b1;
                    end
                end
                default:
                begin
                    acc_next = acc_base;
                end
            endcase
        end
    end

    // Accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (~out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= out_byte_next;
            pad_reg      <= pad_next;
            last_reg     <= last_next;
            err_reg      <= err_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign pad_bits   = pad_reg;
    assign last       = last_reg;
    assign load_error = err_reg;

    // Checks
    `HCBP_ASSERT_NOW(a_cnt_in_range, 1'b1, cnt_reg < hcbp_pkg::CNT_W'(hcbp_pkg::ACC_W))
    `HCBP_ASSERT_NEXT(a_flush_clears, take && is_flush, cnt_reg == '0)
    `HCBP_ASSERT_NEXT(a_more_bytes_follow,
        emit && (cnt_reg >= hcbp_pkg::CNT_W'(2 * hcbp_pkg::BYTE_W)),
        cnt_reg >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W))

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the Huffman code bit packer: table loads, encodes and flushes.
module tb;

    localparam logic [1:0] MODE_NOP = 2'd3;   // undefined mode, block ignores it
    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 300;
    localparam int SHOW_LIMIT  = 10;

    // One input transaction
    typedef struct {
        logic [1:0]                  op;
        logic [hcbp_pkg::SYM_W-1:0]  sym;
        logic [hcbp_pkg::CODE_W-1:0] word;
        logic [hcbp_pkg::LEN_W-1:0]  len;
    } enc_req_t;

    // One output transaction
    typedef struct {
        logic [hcbp_pkg::BYTE_W-1:0] data;
        logic [hcbp_pkg::PAD_W-1:0]  pad;
        logic                        fin;
        logic                        err;
    } packed_byte_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [1:0]                    mode = 2'd0;
    logic [hcbp_pkg::SYM_W-1:0]    symbol = '0;
    logic [hcbp_pkg::CODE_W-1:0]   code_word = '0;
    logic [hcbp_pkg::LEN_W-1:0]    code_length = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [hcbp_pkg::BYTE_W-1:0]   out_byte;
    logic [hcbp_pkg::PAD_W-1:0]    pad_bits;
    logic                          last;
    logic                          load_error;

    // Stimulus and prediction state
    enc_req_t                      encoder_requests[$];
    packed_byte_t                  expected_bytes[$];
    logic [hcbp_pkg::SYM_W-1:0]    live_syms[$];
    logic [hcbp_pkg::CODE_W-1:0]   code_mem[hcbp_pkg::SYMBOL_COUNT] = '{default: '0};
    logic [hcbp_pkg::LEN_W-1:0]    len_mem[hcbp_pkg::SYMBOL_COUNT] = '{default: '0};
    logic [hcbp_pkg::BYTE_W-1:0]   acc_byte = '0;
    int                            acc_fill = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_arm = 1'b0;
    logic hold_on = 1'b0;

    int cycles = 0;
    int n_accepted = 0;
    int n_bytes_checked = 0;
    int n_flush_bytes = 0;
    int n_load_errors = 0;
    int n_full_stalls = 0;
    int n_failures = 0;

    huffman_code_bit_packer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .pad_bits    (pad_bits),
        .last        (last),
        .load_error  (load_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycles, expected_bytes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Predict the bytes one accepted transaction produces
    task automatic pack_request(input enc_req_t r);
        packed_byte_t res[5];
        int           n;
        int           i;
        logic [63:0]  mask;
        logic [hcbp_pkg::CODE_W-1:0] code;
        n = 0;
        if (r.op == hcbp_pkg::MODE_LOAD)
        begin
            if (r.len > hcbp_pkg::LEN_LIMIT)
            begin
                res[0] = '{data: '0, pad: '0, fin: 1'b1, err: 1'b1};
                n = 1;
            end
            else
            begin
                mask = (64'd1 << r.len) - 64'd1;
                code_mem[r.sym] = r.word & mask[hcbp_pkg::CODE_W-1:0];
                len_mem[r.sym]  = r.len;
            end
        end
        else if (r.op == hcbp_pkg::MODE_ENCODE)
        begin
            code = code_mem[r.sym];
            for (i = int'(len_mem[r.sym]); i > 0; i--)
            begin
                if (code[i-1])
                    acc_byte[7-acc_fill] = 1'b1;
                acc_fill++;
                if (acc_fill == 8)
                begin
                    res[n] = '{data: acc_byte, pad: '0, fin: 1'b0, err: 1'b0};
                    n++;
                    acc_byte = '0;
                    acc_fill = 0;
                end
            end
            if (n > 0)
                res[n-1].fin = 1'b1;
        end
        else if (r.op == hcbp_pkg::MODE_FLUSH && acc_fill != 0)
        begin
            res[0] = '{data: acc_byte, pad: hcbp_pkg::PAD_W'(8 - acc_fill),
                       fin: 1'b1, err: 1'b0};
            n = 1;
            acc_byte = '0;
            acc_fill = 0;
        end
        for (i = 0; i < n; i++)
            expected_bytes.push_back(res[i]);
    endtask

    // Driver: offers queued transactions, holds payload while stalled
    always @(posedge clk)
    begin : drive_requests
        enc_req_t nxt;
        enc_req_t taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken = '{op: mode, sym: symbol, word: code_word, len: code_length};
                if (mode != MODE_NOP)
                    n_accepted++;
                pack_request(taken);
            end
            if (hold_on && in_valid && in_stall)
                n_full_stalls++;
            if (!in_valid || !in_stall)
            begin
                if (encoder_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = encoder_requests.pop_front();
                    in_valid    <= 1'b1;
                    mode        <= nxt.op;
                    symbol      <= nxt.sym;
                    code_word   <= nxt.word;
                    code_length <= nxt.len;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, forced high during the long hold-off
    always @(posedge clk)
    begin
        if (hold_on)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Monitor: compare each accepted byte with the oldest prediction
    always @(posedge clk)
    begin : check_bytes
        packed_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                n_failures++;
                if (n_failures <= SHOW_LIMIT)
                    $display("unexpected byte %02h pad %0d last %0b err %0b",
                             out_byte, pad_bits, last, load_error);
            end
            else
            begin
                want = expected_bytes.pop_front();
                n_bytes_checked++;
                if (load_error)
                    n_load_errors++;
                if (pad_bits != 0)
                    n_flush_bytes++;
                if (out_byte !== want.data || pad_bits !== want.pad ||
                    last !== want.fin || load_error !== want.err)
                begin
                    n_failures++;
                    if (n_failures <= SHOW_LIMIT)
                    begin
                        $display("mismatch: expected byte %02h pad %0d last %0b err %0b",
                                 want.data, want.pad, want.fin, want.err);
                        $display("          got      byte %02h pad %0d last %0b err %0b",
                                 out_byte, pad_bits, last, load_error);
                    end
                end
            end
        end
    end

    task automatic queue_item(input logic [1:0] op,
                              input logic [hcbp_pkg::SYM_W-1:0] sym,
                              input logic [hcbp_pkg::CODE_W-1:0] word,
                              input logic [hcbp_pkg::LEN_W-1:0] len);
        encoder_requests.push_back('{op: op, sym: sym, word: word, len: len});
    endtask

    // Random traffic: mostly encodes of loaded symbols, some loads, flushes, noise
    task automatic add_random(input int count);
        int done;
        int pick;
        int r;
        logic [hcbp_pkg::SYM_W-1:0] s;
        logic [hcbp_pkg::LEN_W-1:0] l;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            if (live_syms.size() < 4 || pick < 15)
            begin
                s = hcbp_pkg::SYM_W'($urandom_range(255));
                r = $urandom_range(99);
                if (r < 65)
                    l = hcbp_pkg::LEN_W'($urandom_range(12, 1));
                else if (r < 82)
                    l = hcbp_pkg::LEN_W'($urandom_range(32, 13));
                else if (r < 90)
                    l = '0;
                else
                    l = hcbp_pkg::LEN_W'($urandom_range(63, 33));
                queue_item(hcbp_pkg::MODE_LOAD, s, $urandom, l);
                if (l != 0 && l <= hcbp_pkg::LEN_LIMIT)
                    live_syms.push_back(s);
                done++;
            end
            else if (pick < 82)
            begin
                if ($urandom_range(99) < 88)
                    s = live_syms[$urandom_range(live_syms.size() - 1)];
                else
                    s = hcbp_pkg::SYM_W'($urandom_range(255));
                queue_item(hcbp_pkg::MODE_ENCODE, s, $urandom,
                           hcbp_pkg::LEN_W'($urandom));
                done++;
            end
            else if (pick < 97)
            begin
                queue_item(hcbp_pkg::MODE_FLUSH, hcbp_pkg::SYM_W'($urandom), $urandom,
                           hcbp_pkg::LEN_W'($urandom));
                done++;
            end
            else
            begin
                queue_item(MODE_NOP, hcbp_pkg::SYM_W'($urandom), $urandom,
                           hcbp_pkg::LEN_W'($urandom));
            end
        end
    endtask

    // Sender pause: nothing queued, nothing offered, nothing expected
    task automatic wait_drained();
        do
            @(negedge clk);
        while (encoder_requests.size() != 0 || in_valid || expected_bytes.size() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        @(negedge clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= stall_pct;
    endtask

    initial
    begin
        int leftover;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: length extremes, rejected loads, exact byte fills, flush cases
        queue_item(hcbp_pkg::MODE_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd1);
        queue_item(hcbp_pkg::MODE_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
        queue_item(hcbp_pkg::MODE_LOAD, 8'd128, 32'h0000_0000, 6'd32);
        queue_item(hcbp_pkg::MODE_LOAD, 8'd7, 32'hFFFF_FF55, 6'd7);
        queue_item(hcbp_pkg::MODE_LOAD, 8'd1, 32'hDEAD_BEEF, 6'd0);
        queue_item(hcbp_pkg::MODE_LOAD, 8'd9, 32'hFFFF_FFFF, 6'd33);
        queue_item(hcbp_pkg::MODE_LOAD, 8'd200, 32'h1234_5678, 6'd63);
        queue_item(hcbp_pkg::MODE_FLUSH, 8'd0, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd0, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd255, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd0, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd255, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd1, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd9, 32'h0, 6'd0);
        queue_item(MODE_NOP, 8'd7, 32'hFFFF_FFFF, 6'd8);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd7, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_FLUSH, 8'd0, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd128, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd7, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_FLUSH, 8'd0, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_LOAD, 8'd0, 32'h8000_0001, 6'd32);
        queue_item(hcbp_pkg::MODE_ENCODE, 8'd0, 32'h0, 6'd0);
        queue_item(hcbp_pkg::MODE_FLUSH, 8'd0, 32'h0, 6'd0);
        live_syms.push_back(8'd0);
        live_syms.push_back(8'd7);
        live_syms.push_back(8'd128);
        live_syms.push_back(8'd255);
        wait_drained();

        // Random phases under different idling mixes
        set_idling(0, 0);
        add_random(70);
        wait_drained();
        set_idling(60, 0);
        add_random(70);
        wait_drained();
        set_idling(0, 60);
        add_random(70);
        wait_drained();
        set_idling(37, 37);
        add_random(70);
        wait_drained();

        // Receiver holds off while the sender streams, filling the block
        set_idling(0, 0);
        hold_arm <= 1'b1;
        add_random(70);
        wait_drained();

        repeat (10) @(posedge clk);
        leftover = expected_bytes.size();
        $display("covered %0d transactions: %0d bytes checked, %0d flush bytes, %0d load rejects",
                 n_accepted, n_bytes_checked, n_flush_bytes, n_load_errors);
        $display("input held off %0d cycles during the long output stall, %0d failures, %0d missing",
                 n_full_stalls, n_failures, leftover);
        if (n_failures == 0 && leftover == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
